// File: rtl/dcc_pkg.sv
// Shared types and constants for the DCC packet receiver.
package dcc_pkg;

   // Configuration register indexes and reset values
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_BIT_MAX  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE_MIN = 2'd1;
   localparam logic [15:0] ONE_BIT_MAX_RESET  = 16'd77;
   localparam logic [4:0]  PREAMBLE_MIN_RESET = 5'd9;

   // Packet sizes
   localparam logic [2:0] COUNT_SHORT = 3'd3;
   localparam logic [2:0] COUNT_LONG  = 3'd4;

   // Basic accessory match masks
   localparam logic [7:0] ACC_B1_MASK  = 8'hC0;
   localparam logic [7:0] ACC_B1_MATCH = 8'h80;
   localparam logic [7:0] ACC_B2_MASK  = 8'h88;

   // Framed packet handed from the framer to the decoder
   typedef struct packed {
      logic [2:0] byte_count;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
   } pkt_type;

   // Decoded result
   typedef struct packed {
      logic        acc_output;
      logic [15:0] acc_address;
      logic        is_accessory;
      logic        check_ok;
      logic [7:0]  byte_four;
      logic [7:0]  byte_three;
      logic [7:0]  byte_two;
      logic [7:0]  byte_one;
      logic [2:0]  byte_count;
   } rsp_type;

endpackage

// File: rtl/dcc_packet_receiver.sv
// Top level of the DCC packet receiver: framer, decoder and stream ports.
//
//   channel  direction  payload
//   req_     in         tdata[15:0] half_bit_us
//   rsp_     out        tdata[53:0] packet bytes, check, accessory decode
//   csr_     in         csr_index selects register, csr_data is the value
//
// One half-bit time is taken per cycle while req_tready is high; a packet result
// is registered in the framed-packet stage and then in the result register once
// the transaction that carries its final separator bit is accepted. Reset clears
// the framer to preamble hunting and loads the register defaults. When rsp_tready
// is low the result register holds, the packet stage fills behind it, and
// req_tready drops only while both are full.
module dcc_packet_receiver
   import dcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] half_bit_us
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [55:0]            rsp_tdata,   // [2:0] byte_count, [10:3] byte_one,
                                               // [18:11] byte_two, [26:19] byte_three,
                                               // [34:27] byte_four, [35] check_ok,
                                               // [36] is_accessory, [52:37] acc_address,
                                               // [53] acc_output, [55:54] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   logic    item_fire;
   logic    pkt_valid;
   pkt_type pkt;
   logic    out_free;
   rsp_type rsp;

   // Accept while the packet stage is empty or moving on
   assign req_tready = !pkt_valid || out_free;
   assign item_fire  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   dcc_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_fire   (item_fire),
      .half_bit_us (req_tdata),
      .pkt_take    (out_free),
      .pkt_valid   (pkt_valid),
      .pkt         (pkt)
   );

   dcc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .pkt_valid (pkt_valid),
      .pkt       (pkt),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .out_free  (out_free)
   );

   assign rsp_tdata = {2'b00, rsp};

endmodule

// File: rtl/dcc_framer.sv
// Bit classifier and packet framer with the framed-packet stage register.
module dcc_framer
   import dcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   item_fire,
   input  logic [15:0]            half_bit_us,
   input  logic                   pkt_take,
   output logic                   pkt_valid,
   output pkt_type                pkt
);

   typedef enum logic [3:0] {
      PH_HUNT   = 4'd0,
      PH_START  = 4'd1,
      PH_BIT0   = 4'd2,
      PH_BIT1   = 4'd3,
      PH_BIT2   = 4'd4,
      PH_BIT3   = 4'd5,
      PH_BIT4   = 4'd6,
      PH_BIT5   = 4'd7,
      PH_BIT6   = 4'd8,
      PH_BIT7   = 4'd9,
      PH_SEP1   = 4'd10,
      PH_SEP2   = 4'd11,
      PH_SEP3   = 4'd12,
      PH_SEP4   = 4'd13
   } phase_type;

   logic [15:0] one_max_ff;
   logic [4:0]  pre_min_ff;
   phase_type   phase_ff, phase_in;
   logic [4:0]  ones_ff, ones_in;
   logic [2:0]  done_ff, done_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  held2_ff, held2_in;
   logic [7:0]  held3_ff, held3_in;
   logic        emit;
   pkt_type     emit_pkt;
   logic        pkt_valid_ff;
   pkt_type     pkt_ff;
   logic        one;
   logic [4:0]  ones_next;
   logic [7:0]  shift_next;
   logic [2:0]  done_next;

   // Classify the half-bit time
   assign one        = (half_bit_us <= one_max_ff);
   assign ones_next  = !one ? 5'd0 : ((ones_ff == 5'd31) ? ones_ff : ones_ff + 5'd1);
   assign shift_next = {shift_ff[6:0], one};
   assign done_next  = done_ff + 3'd1;

   // Framing state machine, next values
   always_comb begin
      phase_in = phase_ff;
      ones_in  = ones_ff;
      done_in  = done_ff;
      shift_in = shift_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      held2_in = held2_ff;
      held3_in = held3_ff;
      emit     = 1'b0;
      emit_pkt = '{byte_count: COUNT_SHORT, byte_one: held0_ff, byte_two: held1_ff,
                   byte_three: shift_ff, byte_four: held3_ff};
      case (phase_ff)
         PH_HUNT: begin
            ones_in = ones_next;
            if (ones_next > pre_min_ff) phase_in = PH_START;
         end
         PH_START: begin
            if (!one) begin
               phase_in = PH_BIT0;
               done_in  = 3'd0;
               ones_in  = 5'd0;
               held3_in = 8'd0;
            end
         end
         PH_BIT0: begin shift_in = shift_next; phase_in = PH_BIT1; end
         PH_BIT1: begin shift_in = shift_next; phase_in = PH_BIT2; end
         PH_BIT2: begin shift_in = shift_next; phase_in = PH_BIT3; end
         PH_BIT3: begin shift_in = shift_next; phase_in = PH_BIT4; end
         PH_BIT4: begin shift_in = shift_next; phase_in = PH_BIT5; end
         PH_BIT5: begin shift_in = shift_next; phase_in = PH_BIT6; end
         PH_BIT6: begin shift_in = shift_next; phase_in = PH_BIT7; end
         PH_BIT7: begin
            // Last data bit: count the byte and pick its separator phase
            shift_in = shift_next;
            done_in  = done_next;
            case (done_next)
               3'd1:    phase_in = PH_SEP1;
               3'd2:    phase_in = PH_SEP2;
               3'd3:    phase_in = PH_SEP3;
               3'd4:    phase_in = PH_SEP4;
               default: phase_in = PH_HUNT;
            endcase
         end
         PH_SEP1: begin
            held0_in = shift_ff;
            phase_in = one ? PH_HUNT : PH_BIT0;
         end
         PH_SEP2: begin
            held1_in = shift_ff;
            phase_in = one ? PH_HUNT : PH_BIT0;
         end
         PH_SEP3: begin
            held2_in = shift_ff;
            phase_in = one ? PH_HUNT : PH_BIT0;
            emit     = one;
         end
         PH_SEP4: begin
            // Zero separator after the fourth byte drops the packet
            held3_in = shift_ff;
            phase_in = PH_HUNT;
            emit     = one;
            emit_pkt = '{byte_count: COUNT_LONG, byte_one: held0_ff, byte_two: held1_ff,
                         byte_three: held2_ff, byte_four: shift_ff};
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         one_max_ff <= ONE_BIT_MAX_RESET;
         pre_min_ff <= PREAMBLE_MIN_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ONE_BIT_MAX) one_max_ff <= csr_data;
         else if (csr_index == CSR_PREAMBLE_MIN) pre_min_ff <= csr_data[4:0];
      end
   end

   // Framing state, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         ones_ff  <= 5'd0;
         done_ff  <= 3'd0;
         shift_ff <= 8'd0;
         held0_ff <= 8'd0;
         held1_ff <= 8'd0;
         held2_ff <= 8'd0;
         held3_ff <= 8'd0;
      end else if (item_fire) begin
         phase_ff <= phase_in;
         ones_ff  <= ones_in;
         done_ff  <= done_in;
         shift_ff <= shift_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
         held3_ff <= held3_in;
      end
   end

   // Framed packet stage: load on emit, clear when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_valid_ff <= 1'b0;
      end else if (item_fire && emit) begin
         pkt_valid_ff <= 1'b1;
      end else if (pkt_take) begin
         pkt_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire && emit) pkt_ff <= emit_pkt;
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;

endmodule

// File: rtl/dcc_decode.sv
// Check and basic accessory decode with the result register.
module dcc_decode
   import dcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    pkt_valid,
   input  pkt_type pkt,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp,
   output logic    out_free
);

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        ok;
   logic        acc;
   logic [8:0]  board;
   logic [15:0] board_m1;

   // Decode the framed packet
   assign ok       = ((pkt.byte_one ^ pkt.byte_two ^ pkt.byte_three ^ pkt.byte_four) == 8'd0);
   assign acc      = ok && ((pkt.byte_one & ACC_B1_MASK) == ACC_B1_MATCH)
                        && ((pkt.byte_two & ACC_B2_MASK) == ACC_B2_MASK);
   assign board    = {~pkt.byte_two[6:4], pkt.byte_one[5:0]};
   assign board_m1 = {7'd0, board} - 16'd1;

   always_comb begin
      rsp_in.byte_count   = pkt.byte_count;
      rsp_in.byte_one     = pkt.byte_one;
      rsp_in.byte_two     = pkt.byte_two;
      rsp_in.byte_three   = pkt.byte_three;
      rsp_in.byte_four    = pkt.byte_four;
      rsp_in.check_ok     = ok;
      rsp_in.is_accessory = acc;
      rsp_in.acc_address  = acc ? ({board_m1[13:0], pkt.byte_two[2:1]} + 16'd1) : 16'd0;
      rsp_in.acc_output   = acc & pkt.byte_two[0];
   end

   // Result register: refill when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pkt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pkt_valid) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
